>>> rtl/y86dec_pkg.sv
// ----------------------------------------------------------------------------
// y86dec_pkg
// opcode table, mnemonic codes and shared types of the y86 instruction decoder
// ----------------------------------------------------------------------------
package y86dec_pkg;

    localparam int BYTE_W  = 8;
    localparam int MNEM_W  = 5;
    localparam int REG_W   = 4;
    localparam int IMM_W   = 32;
    localparam int LEN_W   = 3;
    localparam int COUNT_W = 3;

    // opcode bytes
    localparam logic [BYTE_W-1:0] OP_HALT   = 8'h00;
    localparam logic [BYTE_W-1:0] OP_NOP    = 8'h10;
    localparam logic [BYTE_W-1:0] OP_RRMOVL = 8'h20;
    localparam logic [BYTE_W-1:0] OP_CMOVG  = 8'h26;
    localparam logic [BYTE_W-1:0] OP_IRMOVL = 8'h30;
    localparam logic [BYTE_W-1:0] OP_RMMOVL = 8'h40;
    localparam logic [BYTE_W-1:0] OP_MRMOVL = 8'h50;
    localparam logic [BYTE_W-1:0] OP_ADDL   = 8'h60;
    localparam logic [BYTE_W-1:0] OP_XORL   = 8'h63;
    localparam logic [BYTE_W-1:0] OP_JMP    = 8'h70;
    localparam logic [BYTE_W-1:0] OP_JG     = 8'h76;
    localparam logic [BYTE_W-1:0] OP_CALL   = 8'h80;
    localparam logic [BYTE_W-1:0] OP_RET    = 8'h90;
    localparam logic [BYTE_W-1:0] OP_PUSHL  = 8'hA0;
    localparam logic [BYTE_W-1:0] OP_POPL   = 8'hB0;

    // mnemonic codes
    localparam logic [MNEM_W-1:0] MN_HALT   = 5'd0;
    localparam logic [MNEM_W-1:0] MN_NOP    = 5'd1;
    localparam logic [MNEM_W-1:0] MN_RRMOVL = 5'd2;
    localparam logic [MNEM_W-1:0] MN_IRMOVL = 5'd9;
    localparam logic [MNEM_W-1:0] MN_RMMOVL = 5'd10;
    localparam logic [MNEM_W-1:0] MN_MRMOVL = 5'd11;
    localparam logic [MNEM_W-1:0] MN_ADDL   = 5'd12;
    localparam logic [MNEM_W-1:0] MN_JMP    = 5'd16;
    localparam logic [MNEM_W-1:0] MN_CALL   = 5'd23;
    localparam logic [MNEM_W-1:0] MN_RET    = 5'd24;
    localparam logic [MNEM_W-1:0] MN_PUSHL  = 5'd25;
    localparam logic [MNEM_W-1:0] MN_POPL   = 5'd26;

    // instruction lengths
    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_REG   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_DEST  = 3'd5;
    localparam logic [LEN_W-1:0] LEN_FULL  = 3'd6;

    typedef struct packed {
        logic              known;
        logic [MNEM_W-1:0] mnemonic;
        logic [LEN_W-1:0]  length;
    } opclass_t;

    typedef struct packed {
        logic [MNEM_W-1:0] mnemonic;
        logic [REG_W-1:0]  reg_a;
        logic [REG_W-1:0]  reg_b;
        logic [IMM_W-1:0]  immediate;
        logic [LEN_W-1:0]  instr_length;
        logic              invalid;
    } result_t;

    function automatic opclass_t classify(input logic [BYTE_W-1:0] op);
        opclass_t c;
        c.known    = 1'b1;
        c.mnemonic = MN_HALT;
        c.length   = LEN_ONE;
        if (op == OP_HALT)
        begin
            c.mnemonic = MN_HALT;
        end
        else if (op == OP_NOP)
        begin
            c.mnemonic = MN_NOP;
        end
        else if (op >= OP_RRMOVL && op <= OP_CMOVG)
        begin
            c.mnemonic = MN_RRMOVL + {2'b00, op[2:0]};
            c.length   = LEN_REG;
        end
        else if (op == OP_IRMOVL)
        begin
            c.mnemonic = MN_IRMOVL;
            c.length   = LEN_FULL;
        end
        else if (op == OP_RMMOVL)
        begin
            c.mnemonic = MN_RMMOVL;
            c.length   = LEN_FULL;
        end
        else if (op == OP_MRMOVL)
        begin
            c.mnemonic = MN_MRMOVL;
            c.length   = LEN_FULL;
        end
        else if (op >= OP_ADDL && op <= OP_XORL)
        begin
            c.mnemonic = MN_ADDL + {3'b000, op[1:0]};
            c.length   = LEN_REG;
        end
        else if (op >= OP_JMP && op <= OP_JG)
        begin
            c.mnemonic = MN_JMP + {2'b00, op[2:0]};
            c.length   = LEN_DEST;
        end
        else if (op == OP_CALL)
        begin
            c.mnemonic = MN_CALL;
            c.length   = LEN_DEST;
        end
        else if (op == OP_RET)
        begin
            c.mnemonic = MN_RET;
        end
        else if (op == OP_PUSHL)
        begin
            c.mnemonic = MN_PUSHL;
            c.length   = LEN_REG;
        end
        else if (op == OP_POPL)
        begin
            c.mnemonic = MN_POPL;
            c.length   = LEN_REG;
        end
        else
        begin
            c.known = 1'b0;
        end
        return c;
    endfunction

endpackage

>>> rtl/y86dec_byte_if.sv
// ----------------------------------------------------------------------------
// y86dec_byte_if
// valid/ready channel carrying one code byte per transaction
// ----------------------------------------------------------------------------
interface y86dec_byte_if;
    logic                           valid;
    logic                           ready;
    logic [y86dec_pkg::BYTE_W-1:0]  code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink   (input valid, input code_byte, output ready);
endinterface

>>> rtl/y86dec_result_if.sv
// ----------------------------------------------------------------------------
// y86dec_result_if
// valid/ready channel carrying one decoded instruction per transaction
// ----------------------------------------------------------------------------
interface y86dec_result_if;
    logic                           valid;
    logic                           ready;
    logic [y86dec_pkg::MNEM_W-1:0]  mnemonic;
    logic [y86dec_pkg::REG_W-1:0]   reg_a;
    logic [y86dec_pkg::REG_W-1:0]   reg_b;
    logic [y86dec_pkg::IMM_W-1:0]   immediate;
    logic [y86dec_pkg::LEN_W-1:0]   instr_length;
    logic                           invalid;

    modport source (output valid, output mnemonic, output reg_a, output reg_b,
                    output immediate, output instr_length, output invalid,
                    input ready);
    modport sink   (input valid, input mnemonic, input reg_a, input reg_b,
                    input immediate, input instr_length, input invalid,
                    output ready);
endinterface

>>> rtl/y86dec_in_stage.sv
// ----------------------------------------------------------------------------
// y86dec_in_stage
// input register: holds one accepted code byte until the decode step takes it
// ----------------------------------------------------------------------------
module y86dec_in_stage (
    input  logic                           clk,
    input  logic                           rst_n,
    y86dec_byte_if.sink                    code_in,
    input  logic                           step,
    output logic                           byte_valid,
    output logic [y86dec_pkg::BYTE_W-1:0]  code_byte
);

    logic                           valid_reg;
    logic                           valid_next;
    logic [y86dec_pkg::BYTE_W-1:0]  byte_reg;
    logic                           take;

    // free when empty or when the held byte leaves this cycle
    assign code_in.ready = !valid_reg || step;
    assign take          = code_in.valid && code_in.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= code_in.code_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign code_byte  = byte_reg;

endmodule

>>> rtl/y86dec_decode.sv
// ----------------------------------------------------------------------------
// y86dec_decode
// instruction assembly state: opcode, register byte, immediate and byte count
// ----------------------------------------------------------------------------
module y86dec_decode (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [y86dec_pkg::BYTE_W-1:0]  code_byte,
    output logic                           res_valid,
    output y86dec_pkg::result_t            result
);

    logic [y86dec_pkg::COUNT_W-1:0] count_reg;
    logic [y86dec_pkg::COUNT_W-1:0] count_next;
    logic [y86dec_pkg::BYTE_W-1:0]  opcode_reg;
    logic [y86dec_pkg::BYTE_W-1:0]  opcode_next;
    logic [y86dec_pkg::BYTE_W-1:0]  regbyte_reg;
    logic [y86dec_pkg::BYTE_W-1:0]  regbyte_next;
    logic [y86dec_pkg::IMM_W-1:0]   imm_reg;
    logic [y86dec_pkg::IMM_W-1:0]   imm_next;

    y86dec_pkg::opclass_t           new_cls;
    y86dec_pkg::opclass_t           held_cls;
    logic [y86dec_pkg::COUNT_W-1:0] pos;
    logic [y86dec_pkg::COUNT_W-1:0] count_inc;

    assign new_cls   = y86dec_pkg::classify(code_byte);
    assign held_cls  = y86dec_pkg::classify(opcode_reg);
    assign count_inc = count_reg + 3'd1;
    assign pos       = (held_cls.length == y86dec_pkg::LEN_FULL) ? count_reg - 3'd2
                                                                  : count_reg - 3'd1;

    always_comb
    begin
        count_next   = count_reg;
        opcode_next  = opcode_reg;
        regbyte_next = regbyte_reg;
        imm_next     = imm_reg;
        res_valid    = 1'b0;
        result       = '0;
        result.instr_length = y86dec_pkg::LEN_ONE;

        if (step)
        begin
            if (count_reg == '0)
            begin
                if (!new_cls.known)
                begin
                    res_valid      = 1'b1;
                    result.invalid = 1'b1;
                end
                else if (new_cls.length == y86dec_pkg::LEN_ONE)
                begin
                    res_valid       = 1'b1;
                    result.mnemonic = new_cls.mnemonic;
                end
                else
                begin
                    opcode_next  = code_byte;
                    regbyte_next = '0;
                    imm_next     = '0;
                    count_next   = 3'd1;
                end
            end
            else if (held_cls.length < y86dec_pkg::LEN_REG
                     || count_reg >= held_cls.length)
            begin
                // inconsistent state, restart on the next opcode
                count_next = '0;
            end
            else
            begin
                if ((held_cls.length == y86dec_pkg::LEN_REG
                     || held_cls.length == y86dec_pkg::LEN_FULL) && count_reg == 3'd1)
                begin
                    regbyte_next = code_byte;
                end
                else
                begin
                    imm_next = imm_reg | ({24'b0, code_byte} << {pos[1:0], 3'b000});
                end

                if (count_inc == held_cls.length)
                begin
                    res_valid           = 1'b1;
                    result.mnemonic     = held_cls.mnemonic;
                    result.reg_a        = regbyte_next[7:4];
                    result.reg_b        = regbyte_next[3:0];
                    result.immediate    = imm_next;
                    result.instr_length = held_cls.length;
                    count_next          = '0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            opcode_reg  <= '0;
            regbyte_reg <= '0;
            imm_reg     <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            opcode_reg  <= opcode_next;
            regbyte_reg <= regbyte_next;
            imm_reg     <= imm_next;
        end
    end

endmodule

>>> rtl/y86dec_out_stage.sv
// ----------------------------------------------------------------------------
// y86dec_out_stage
// result register driving the output channel
// ----------------------------------------------------------------------------
module y86dec_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  y86dec_pkg::result_t   result,
    output logic                  free,
    y86dec_result_if.source       result_out
);

    logic                 valid_reg;
    logic                 valid_next;
    y86dec_pkg::result_t  data_reg;

    assign free = !valid_reg || result_out.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign result_out.valid        = valid_reg;
    assign result_out.mnemonic     = data_reg.mnemonic;
    assign result_out.reg_a        = data_reg.reg_a;
    assign result_out.reg_b        = data_reg.reg_b;
    assign result_out.immediate    = data_reg.immediate;
    assign result_out.instr_length = data_reg.instr_length;
    assign result_out.invalid      = data_reg.invalid;

endmodule

>>> rtl/y86_instruction_decoder_top.sv
// ----------------------------------------------------------------------------
// y86_instruction_decoder_top
// decodes a y86 code byte stream into one result per complete instruction
// ----------------------------------------------------------------------------
//  channel     dir  payload                                         transaction
//  code_in     in   code_byte[7:0]                                  one code byte
//  result_out  out  mnemonic, reg_a, reg_b, immediate,              one instruction
//                   instr_length, invalid
//
//  one code byte per cycle while result_out does not stall; a byte passes input
//  register, decode and result register in that order, and the result register holds each result
//  the decode state updates each cycle a byte leaves the input register
//  reset clears the byte count and all held instruction fields
//  a stalled result_out holds the result register and backs up code_in
//  an unknown opcode gives one result flagged invalid and is skipped
// ----------------------------------------------------------------------------
module y86_instruction_decoder_top (
    input  logic               clk,
    input  logic               rst_n,
    y86dec_byte_if.sink        code_in,
    y86dec_result_if.source    result_out
);

    logic                           step;
    logic                           free;
    logic                           byte_valid;
    logic [y86dec_pkg::BYTE_W-1:0]  code_byte;
    logic                           res_valid;
    y86dec_pkg::result_t            result;

    assign step = byte_valid && free;

    y86dec_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_in    (code_in),
        .step       (step),
        .byte_valid (byte_valid),
        .code_byte  (code_byte)
    );

    y86dec_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .code_byte (code_byte),
        .res_valid (res_valid),
        .result    (result)
    );

    y86dec_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (res_valid),
        .result     (result),
        .free       (free),
        .result_out (result_out)
    );

endmodule
